FILE: hw/rtl/perlin_noise_3d_octaves_core_defines.svh
// Assertion macros for the fractal noise core.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef PERLIN_NOISE_3D_OCTAVES_CORE_DEFINES_SVH
`define PERLIN_NOISE_3D_OCTAVES_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PN_ASSERT(lbl, prop, msg) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	prop) else $error(msg);
`define PN_ASSERT_RST(lbl, prop, msg) lbl: assert property (@(posedge clk) prop) \
	else $error(msg);
`else
`define PN_ASSERT(lbl, prop, msg)
`define PN_ASSERT_RST(lbl, prop, msg)
`endif
`endif

FILE: hw/rtl/pnoise_pkg.sv
// Shared constants, types and functions of the fractal noise core.
// Holds the permutation table and the gradient function; no dependencies.
`default_nettype none
package pnoise_pkg;

	localparam int FRAC_BITS       = 16;
	localparam int ONE             = 1 << FRAC_BITS;
	localparam int MAX_OCTAVES_DEF = 8;
	localparam int LATTICE_SIZE    = 256;
	localparam int LATTICE_BITS    = $clog2(LATTICE_SIZE);
	localparam int DIV_CNT_W       = 6;
	localparam int GIN_W           = FRAC_BITS + 2;

	localparam logic [1:0] REG_OCTAVES = 2'd0;
	localparam logic [1:0] REG_PERSIST = 2'd1;
	localparam logic [1:0] REG_REPEAT  = 2'd2;

	typedef struct packed {
		logic                 start;
		logic [DIV_CNT_W-1:0] steps;
	} div_req_t;

	localparam logic [7:0] PERM [LATTICE_SIZE] = '{
		8'd151, 8'd160, 8'd137, 8'd91, 8'd90, 8'd15, 8'd131, 8'd13, 8'd201, 8'd95,
		8'd96, 8'd53, 8'd194, 8'd233, 8'd7, 8'd225, 8'd140, 8'd36, 8'd103, 8'd30,
		8'd69, 8'd142, 8'd8, 8'd99, 8'd37, 8'd240, 8'd21, 8'd10, 8'd23, 8'd190,
		8'd6, 8'd148, 8'd247, 8'd120, 8'd234, 8'd75, 8'd0, 8'd26, 8'd197, 8'd62,
		8'd94, 8'd252, 8'd219, 8'd203, 8'd117, 8'd35, 8'd11, 8'd32, 8'd57, 8'd177,
		8'd33, 8'd88, 8'd237, 8'd149, 8'd56, 8'd87, 8'd174, 8'd20, 8'd125, 8'd136,
		8'd171, 8'd168, 8'd68, 8'd175, 8'd74, 8'd165, 8'd71, 8'd134, 8'd139, 8'd48,
		8'd27, 8'd166, 8'd77, 8'd146, 8'd158, 8'd231, 8'd83, 8'd111, 8'd229, 8'd122,
		8'd60, 8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92, 8'd41, 8'd55, 8'd46,
		8'd245, 8'd40, 8'd244, 8'd102, 8'd143, 8'd54, 8'd65, 8'd25, 8'd63, 8'd161,
		8'd1, 8'd216, 8'd80, 8'd73, 8'd209, 8'd76, 8'd132, 8'd187, 8'd208, 8'd89,
		8'd18, 8'd169, 8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
		8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3, 8'd64, 8'd52, 8'd217,
		8'd226, 8'd250, 8'd124, 8'd123, 8'd5, 8'd202, 8'd38, 8'd147, 8'd118, 8'd126,
		8'd255, 8'd82, 8'd85, 8'd212, 8'd207, 8'd206, 8'd59, 8'd227, 8'd47, 8'd16,
		8'd58, 8'd17, 8'd182, 8'd189, 8'd28, 8'd42, 8'd223, 8'd183, 8'd170, 8'd213,
		8'd119, 8'd248, 8'd152, 8'd2, 8'd44, 8'd154, 8'd163, 8'd70, 8'd221, 8'd153,
		8'd101, 8'd155, 8'd167, 8'd43, 8'd172, 8'd9, 8'd129, 8'd22, 8'd39, 8'd253,
		8'd19, 8'd98, 8'd108, 8'd110, 8'd79, 8'd113, 8'd224, 8'd232, 8'd178, 8'd185,
		8'd112, 8'd104, 8'd218, 8'd246, 8'd97, 8'd228, 8'd251, 8'd34, 8'd242, 8'd193,
		8'd238, 8'd210, 8'd144, 8'd12, 8'd191, 8'd179, 8'd162, 8'd241, 8'd81, 8'd51,
		8'd145, 8'd235, 8'd249, 8'd14, 8'd239, 8'd107, 8'd49, 8'd192, 8'd214, 8'd31,
		8'd181, 8'd199, 8'd106, 8'd157, 8'd184, 8'd84, 8'd204, 8'd176, 8'd115, 8'd121,
		8'd50, 8'd45, 8'd127, 8'd4, 8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
		8'd222, 8'd114, 8'd67, 8'd29, 8'd24, 8'd72, 8'd243, 8'd141, 8'd128, 8'd195,
		8'd78, 8'd66, 8'd215, 8'd61, 8'd156, 8'd180
	};

	function automatic logic signed [GIN_W:0] grad(
		input logic [3:0]              h,
		input logic signed [GIN_W-1:0] x,
		input logic signed [GIN_W-1:0] y,
		input logic signed [GIN_W-1:0] z
	);
		logic signed [GIN_W:0] xe;
		logic signed [GIN_W:0] ye;
		logic signed [GIN_W:0] ze;
		logic signed [GIN_W:0] r;
		xe = {x[GIN_W-1], x};
		ye = {y[GIN_W-1], y};
		ze = {z[GIN_W-1], z};
		unique case (h)
			4'h0: r = xe + ye;
			4'h1: r = ye - xe;
			4'h2: r = xe - ye;
			4'h3: r = -xe - ye;
			4'h4: r = xe + ze;
			4'h5: r = ze - xe;
			4'h6: r = xe - ze;
			4'h7: r = -xe - ze;
			4'h8: r = ye + ze;
			4'h9: r = ze - ye;
			4'hA: r = ye - ze;
			4'hB: r = -ye - ze;
			4'hC: r = ye + xe;
			4'hD: r = ze - ye;
			4'hE: r = ye - xe;
			4'hF: r = -ye - ze;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/pnoise_mul.sv
// Shared signed multiplier with a registered product.
// Stand-alone; used by the sequencer for every fixed-point product.
`default_nettype none
module pnoise_mul #(
	parameter int MW = 25
) (
	input  wire logic                   clk,
	input  wire logic signed [MW-1:0]   a,
	input  wire logic signed [MW-1:0]   b,
	output logic signed [2*MW-1:0]      p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule
`default_nettype wire

FILE: hw/rtl/pnoise_div.sv
// Restoring divider, one quotient bit per cycle, shared for modulo and the final mean.
// Depends on pnoise_pkg for the request type.
`default_nettype none
module pnoise_div #(
	parameter int TW = 39,
	parameter int DW = 23
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire pnoise_pkg::div_req_t req,
	input  wire logic [TW-1:0]        dividend,
	input  wire logic [DW-1:0]        divisor,
	output logic [TW-1:0]             quotient,
	output logic [DW-1:0]             remainder,
	output logic                      busy
);

	logic [TW-1:0]                    dvd_q;
	logic [DW-1:0]                    dvs_q;
	logic [DW-1:0]                    rem_q;
	logic [pnoise_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [DW:0]                      sh;
	logic [DW+1:0]                    diff;
	logic                             ge;

	assign sh   = {rem_q, dvd_q[TW-1]};
	assign diff = {1'b0, sh} - {2'b00, dvs_q};
	assign ge   = !diff[DW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= req.steps;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[TW-2:0], ge};
			rem_q <= ge ? diff[DW-1:0] : sh[DW-1:0];
		end
	end

	assign quotient  = dvd_q;
	assign remainder = rem_q;
	assign busy      = cnt_q != '0;

endmodule
`default_nettype wire

FILE: hw/rtl/perlin_noise_3d_octaves_core.sv
// Top level of the fractal 3D gradient noise core: sequencer, registers, ports.
// Depends on pnoise_pkg, pnoise_mul, pnoise_div and the assertion macro header.
//
// Usage: a point (coord_x, coord_y, coord_z, unsigned Q16.16) is taken as one
// transaction on the coord channel (coord_valid/coord_ready). The result
// noise_value (Q0.16) leaves as one transaction on the noise channel.
// The core works on one point at a time and holds coord_ready low meanwhile.
// Each octave passes the scaled point through one shared multiplier and one
// permutation table read port; when repeat_period is non-zero, the three
// modulo steps also use the shared divider. The final weighted mean is
// computed in that divider and then loaded into the output register.
// A finished result waits in the output register; while it is not
// taken the next point may be processed up to that register.
// Reset clears the sequencer and returns the registers to one octave,
// persistence 0.5 and no wrapping. The user must write configuration over the APB
// port only while the core is idle; the core itself does not enforce this.
`default_nettype none
`include "perlin_noise_3d_octaves_core_defines.svh"
module perlin_noise_3d_octaves_core #(
	parameter int MAX_OCTAVES = pnoise_pkg::MAX_OCTAVES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        coord_valid,
	output logic             coord_ready,
	input  wire logic [31:0] coord_x,
	input  wire logic [31:0] coord_y,
	input  wire logic [31:0] coord_z,
	output logic             noise_valid,
	input  wire logic        noise_ready,
	output logic [15:0]      noise_value
);

	localparam int F     = pnoise_pkg::FRAC_BITS;
	localparam int ONE   = pnoise_pkg::ONE;
	localparam int GW    = pnoise_pkg::GIN_W;
	localparam int OW    = $clog2(MAX_OCTAVES + 1);
	localparam int AW    = 15 + MAX_OCTAVES;
	localparam int WW    = AW;
	localparam int TW    = 31 + MAX_OCTAVES;
	localparam int MW    = (AW + 1 > 25) ? AW + 1 : 25;
	localparam int SXW   = (32 + MAX_OCTAVES > F + 24) ? 32 + MAX_OCTAVES : F + 24;
	localparam int SH_DN = (F > 16) ? F - 16 : 0;
	localparam int SH_UP = (F < 16) ? 16 - F : 0;
	localparam int CW    = pnoise_pkg::DIV_CNT_W;

	localparam logic signed [MW-1:0] C_ONE = MW'(ONE);
	localparam logic signed [MW-1:0] C_15  = MW'(15 * ONE);
	localparam logic signed [MW-1:0] C_10  = MW'(10 * ONE);

	typedef enum logic [3:0] {
		S_IDLE, S_SPLIT, S_MOD_GO, S_MOD_WAIT, S_FADE, S_HASH, S_LERP, S_ACC,
		S_DIV_GO, S_DIV_WAIT, S_FIN
	} state_t;

	state_t                 state_q;
	logic [3:0]             octaves_q;
	logic [15:0]            persist_q;
	logic [7:0]             repeat_q;

	logic [31:0]            crd_q [3];
	logic [OW-1:0]          n_q;
	logic [OW-1:0]          oct_q;
	logic [7:0]             cell_q [3];
	logic [7:0]             next_q [3];
	logic [F-1:0]           frac_q [3];
	logic [F:0]             fade_q [3];
	logic [1:0]             ci_q;
	logic [2:0]             step_q;
	logic                   mph_q;
	logic [2:0]             corner_q;
	logic [1:0]             hs_q;
	logic [7:0]             h_q;
	logic signed [MW-1:0]   g_q [8];
	logic [3:0]             qn_q;
	logic [TW-1:0]          total_q;
	logic [WW-1:0]          wsum_q;
	logic [AW-1:0]          amp_q;
	logic signed [MW-1:0]   op_a_q;
	logic signed [MW-1:0]   op_b_q;
	logic [15:0]            noise_q;
	logic                   nvalid_q;

	logic signed [2*MW-1:0] p_q;
	logic signed [2*MW-1:0] p_sh;
	logic signed [MW-1:0]   fl;
	pnoise_pkg::div_req_t   div_req;
	logic [TW-1:0]          div_dvd;
	logic [WW-1:0]          div_dvs;
	logic [TW-1:0]          div_quo;
	logic [WW-1:0]          div_rem;
	logic                   div_busy;

	logic [7:0]             sp_cell [3];
	logic [F-1:0]           sp_frac [3];
	logic [SXW-1:0]         sp_s;
	logic [23:0]            sp_ip;
	logic [7:0]             xs;
	logic [7:0]             ys;
	logic [7:0]             zs;
	logic [7:0]             rom_addr;
	logic [7:0]             rom_out;
	logic signed [GW-1:0]   gx;
	logic signed [GW-1:0]   gy;
	logic signed [GW-1:0]   gz;
	logic signed [GW:0]     gr;
	logic signed [MW-1:0]   gr_ext;
	logic signed [MW-1:0]   t_s;
	logic signed [MW-1:0]   lw;
	logic signed [MW-1:0]   lerp_res;
	logic signed [MW-1:0]   nv_r;
	logic [F:0]             nv;
	logic [F:0]             fade_clamp;
	logic [3:0]             qn_m2;
	logic [OW-1:0]          oct_nx;
	logic [3:0]             n_sat;
	logic [TW-1:0]          q_scaled;
	logic                   cfg_wr;

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octaves_q <= 4'd1;
			persist_q <= 16'd16384;
			repeat_q  <= 8'd0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				pnoise_pkg::REG_OCTAVES: octaves_q <= pwdata[3:0];
				pnoise_pkg::REG_PERSIST: persist_q <= pwdata[15:0];
				pnoise_pkg::REG_REPEAT:  repeat_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			pnoise_pkg::REG_OCTAVES: prdata = {28'd0, octaves_q};
			pnoise_pkg::REG_PERSIST: prdata = {16'd0, persist_q};
			pnoise_pkg::REG_REPEAT:  prdata = {24'd0, repeat_q};
			default:                 prdata = '0;
		endcase
	end

	// Shared units.
	pnoise_mul #(.MW(MW)) u_mul (
		.clk (clk),
		.a   (op_a_q),
		.b   (op_b_q),
		.p_q (p_q)
	);

	pnoise_div #(.TW(TW), .DW(WW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (div_req),
		.dividend  (div_dvd),
		.divisor   (div_dvs),
		.quotient  (div_quo),
		.remainder (div_rem),
		.busy      (div_busy)
	);

	always_comb begin
		div_req.start = (state_q == S_MOD_GO) || (state_q == S_DIV_GO);
		if (state_q == S_DIV_GO) begin
			div_req.steps = CW'(TW);
			div_dvd       = total_q;
			div_dvs       = wsum_q;
		end else begin
			div_req.steps = CW'(9);
			div_dvd       = {({1'b0, cell_q[ci_q]} + 9'd1), {(TW-9){1'b0}}};
			div_dvs       = WW'(repeat_q);
		end
	end

	assign p_sh = p_q >>> F;
	assign fl   = p_sh[MW-1:0];

	// Lattice cell and fraction of each scaled coordinate, with the single fold.
	always_comb begin
		sp_s  = '0;
		sp_ip = '0;
		for (int c = 0; c < 3; c++) begin
			sp_s  = SXW'(crd_q[c]) << oct_q;
			sp_ip = sp_s[F+23:F];
			sp_frac[c] = sp_s[F-1:0];
			if (repeat_q != 8'd0 && {sp_ip, sp_s[F-1:0]} > {16'd0, repeat_q, {F{1'b0}}})
				sp_ip = sp_ip - 24'(repeat_q);
			sp_cell[c] = sp_ip[7:0];
		end
	end

	// Corner hashing, one table read a cycle.
	assign xs       = corner_q[0] ? next_q[0] : cell_q[0];
	assign ys       = corner_q[1] ? next_q[1] : cell_q[1];
	assign zs       = corner_q[2] ? next_q[2] : cell_q[2];
	assign rom_addr = (hs_q == 2'd0) ? xs : h_q + ((hs_q == 2'd1) ? ys : zs);
	assign rom_out  = pnoise_pkg::PERM[rom_addr];
	assign gx       = {2'b00, frac_q[0]} - (corner_q[0] ? GW'(ONE) : GW'(0));
	assign gy       = {2'b00, frac_q[1]} - (corner_q[1] ? GW'(ONE) : GW'(0));
	assign gz       = {2'b00, frac_q[2]} - (corner_q[2] ? GW'(ONE) : GW'(0));
	assign gr       = pnoise_pkg::grad(rom_out[3:0], gx, gy, gz);
	assign gr_ext   = {{(MW-GW-1){gr[GW]}}, gr};

	assign t_s      = {{(MW-F){1'b0}}, frac_q[ci_q]};
	assign lw       = (qn_q >= 4'd5) ? {{(MW-F-1){1'b0}}, fade_q[0]} :
	                  (qn_q >= 4'd3) ? {{(MW-F-1){1'b0}}, fade_q[1]} :
	                                   {{(MW-F-1){1'b0}}, fade_q[2]};
	assign lerp_res = g_q[0] + fl;
	assign qn_m2    = qn_q - 4'd2;
	assign oct_nx   = oct_q + OW'(1);

	always_comb begin
		if (fl < 0)
			fade_clamp = '0;
		else if (fl > C_ONE)
			fade_clamp = (F+1)'(ONE);
		else
			fade_clamp = fl[F:0];
	end

	always_comb begin
		nv_r = g_q[0] + C_ONE;
		if (nv_r < 0)
			nv_r = '0;
		nv_r = nv_r >>> 1;
		if (nv_r > C_ONE)
			nv = (F+1)'(ONE);
		else
			nv = nv_r[F:0];
	end

	always_comb begin
		if (octaves_q == 4'd0)
			n_sat = 4'd1;
		else if (32'(octaves_q) > 32'(MAX_OCTAVES))
			n_sat = 4'(MAX_OCTAVES);
		else
			n_sat = octaves_q;
	end

	always_comb begin
		q_scaled = (div_quo >> SH_DN) << SH_UP;
	end

	// Sequencer and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			nvalid_q <= 1'b0;
			ci_q     <= '0;
			step_q   <= '0;
			mph_q    <= 1'b0;
			corner_q <= '0;
			hs_q     <= '0;
			qn_q     <= '0;
			oct_q    <= '0;
		end else begin
			if (nvalid_q && noise_ready && state_q != S_FIN)
				nvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (coord_valid) begin
						oct_q   <= '0;
						state_q <= S_SPLIT;
					end
				end
				S_SPLIT: begin
					ci_q    <= '0;
					step_q  <= '0;
					state_q <= (repeat_q != 8'd0) ? S_MOD_GO : S_FADE;
				end
				S_MOD_GO: begin
					state_q <= S_MOD_WAIT;
				end
				S_MOD_WAIT: begin
					if (!div_busy) begin
						if (ci_q == 2'd2) begin
							ci_q    <= '0;
							state_q <= S_FADE;
						end else begin
							ci_q    <= ci_q + 2'd1;
							state_q <= S_MOD_GO;
						end
					end
				end
				S_FADE: begin
					if (step_q == 3'd0) begin
						step_q <= 3'd1;
						mph_q  <= 1'b0;
					end else if (!mph_q) begin
						mph_q <= 1'b1;
					end else if (step_q == 3'd4) begin
						step_q <= 3'd0;
						if (ci_q == 2'd2) begin
							ci_q     <= '0;
							corner_q <= '0;
							hs_q     <= '0;
							qn_q     <= '0;
							state_q  <= S_HASH;
						end else begin
							ci_q <= ci_q + 2'd1;
						end
					end else begin
						step_q <= step_q + 3'd1;
						mph_q  <= 1'b0;
					end
				end
				S_HASH: begin
					if (hs_q == 2'd2) begin
						hs_q     <= '0;
						qn_q     <= qn_q + 4'd1;
						corner_q <= corner_q + 3'd1;
						if (corner_q == 3'd7) begin
							step_q  <= '0;
							state_q <= S_LERP;
						end
					end else begin
						hs_q <= hs_q + 2'd1;
					end
				end
				S_LERP: begin
					if (step_q == 3'd0) begin
						step_q <= 3'd1;
						mph_q  <= 1'b0;
					end else if (!mph_q) begin
						mph_q <= 1'b1;
					end else begin
						step_q <= 3'd0;
						qn_q   <= qn_q - 4'd1;
						if (qn_q == 4'd2)
							state_q <= S_ACC;
					end
				end
				S_ACC: begin
					if (step_q == 3'd0) begin
						step_q <= 3'd1;
						mph_q  <= 1'b0;
					end else if (!mph_q) begin
						mph_q <= 1'b1;
					end else if (step_q == 3'd1) begin
						step_q <= 3'd2;
						mph_q  <= 1'b0;
					end else begin
						step_q <= 3'd0;
						oct_q  <= oct_nx;
						state_q <= (oct_nx == n_q) ? S_DIV_GO : S_SPLIT;
					end
				end
				S_DIV_GO: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (!div_busy)
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (!nvalid_q || noise_ready) begin
						nvalid_q <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (coord_valid) begin
					crd_q[0] <= coord_x;
					crd_q[1] <= coord_y;
					crd_q[2] <= coord_z;
					n_q      <= OW'(n_sat);
					total_q  <= '0;
					wsum_q   <= '0;
					amp_q    <= AW'(32768);
				end
			end
			S_SPLIT: begin
				for (int c = 0; c < 3; c++) begin
					cell_q[c] <= sp_cell[c];
					frac_q[c] <= sp_frac[c];
					next_q[c] <= sp_cell[c] + 8'd1;
				end
			end
			S_MOD_WAIT: begin
				if (!div_busy)
					next_q[ci_q] <= div_rem[7:0];
			end
			S_FADE: begin
				if (step_q == 3'd0) begin
					op_a_q <= t_s;
					op_b_q <= (t_s <<< 2) + (t_s <<< 1) - C_15;
				end else if (mph_q) begin
					unique case (step_q)
						3'd1: begin
							op_a_q <= t_s;
							op_b_q <= fl + C_10;
						end
						3'd2, 3'd3: begin
							op_a_q <= fl;
							op_b_q <= t_s;
						end
						default: fade_q[ci_q] <= fade_clamp;
					endcase
				end
			end
			S_HASH: begin
				h_q <= rom_out;
				if (hs_q == 2'd2)
					g_q[qn_q[2:0]] <= gr_ext;
			end
			S_LERP: begin
				if (step_q == 3'd0) begin
					op_a_q <= lw;
					op_b_q <= g_q[1] - g_q[0];
				end else if (mph_q) begin
					for (int k = 0; k < 8; k++) begin
						if (4'(k) == qn_m2)
							g_q[k] <= lerp_res;
						else if (k < 6)
							g_q[k] <= g_q[k+2];
					end
				end
			end
			S_ACC: begin
				if (step_q == 3'd0) begin
					op_a_q <= {{(MW-F-1){1'b0}}, nv};
					op_b_q <= {{(MW-AW){1'b0}}, amp_q};
				end else if (mph_q && step_q == 3'd1) begin
					total_q <= total_q + p_q[TW-1:0];
					wsum_q  <= wsum_q + amp_q;
					op_a_q  <= {{(MW-AW){1'b0}}, amp_q};
					op_b_q  <= {{(MW-16){1'b0}}, persist_q};
				end else if (mph_q) begin
					amp_q <= p_q[AW+14:15];
				end
			end
			S_FIN: begin
				if (!nvalid_q || noise_ready)
					noise_q <= (q_scaled > TW'(65535)) ? 16'hFFFF : q_scaled[15:0];
			end
			default: ;
		endcase
	end

	assign coord_ready = state_q == S_IDLE;
	assign noise_valid = nvalid_q;
	assign noise_value = noise_q;

	`PN_ASSERT(a_one_item, (coord_valid && coord_ready) |=> !coord_ready, "second point taken while busy")
	`PN_ASSERT(a_hash_fill, (state_q == S_HASH) |-> (qn_q == {1'b0, corner_q}), "corner queue out of step")
	`PN_ASSERT(a_lerp_done, (state_q == S_ACC) |-> (qn_q == 4'd1), "blend queue not reduced to one value")
	`PN_ASSERT_RST(a_rst_quiet, !arst_n |-> !noise_valid, "result valid during reset")

endmodule
`default_nettype wire

FILE: test/noise_checker.sv
// Checker for the fractal 3D gradient noise core: follows the register writes,
// predicts each noise value from the accepted point and compares it in order.
// Depends on pnoise_pkg for the permutation table and the register indexes.
module noise_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        coord_valid,
	input  logic        coord_ready,
	input  logic [31:0] coord_x,
	input  logic [31:0] coord_y,
	input  logic [31:0] coord_z,
	input  logic        noise_valid,
	input  logic        noise_ready,
	input  logic [15:0] noise_value,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint FX_ONE = 64'd65536;

	logic [3:0]  octaves_q;
	logic [15:0] persist_q;
	logic [7:0]  period_q;
	logic [15:0] expected_noise [$];

	function automatic longint fx_mul(input longint a, input longint b);
		return (a * b) >>> 16;
	endfunction

	function automatic longint fade(input longint t);
		longint r;
		r = fx_mul(t, 6 * t - 15 * FX_ONE) + 10 * FX_ONE;
		r = fx_mul(t, r);
		r = fx_mul(r, t);
		r = fx_mul(r, t);
		if (r < 0) r = 0;
		if (r > FX_ONE) r = FX_ONE;
		return r;
	endfunction

	function automatic longint blend(input longint a, input longint b, input longint w);
		return a + fx_mul(w, b - a);
	endfunction

	function automatic longint corner_dot(input int h, input longint x, input longint y,
			input longint z);
		case (h & 15)
			0: return x + y;
			1: return -x + y;
			2: return x - y;
			3: return -x - y;
			4: return x + z;
			5: return -x + z;
			6: return x - z;
			7: return -x - z;
			8: return y + z;
			9: return -y + z;
			10: return y - z;
			11: return -y - z;
			12: return y + x;
			13: return -y + z;
			14: return y - x;
			default: return -y - z;
		endcase
	endfunction

	function automatic int step_cell(input int n);
		return (period_q != 0) ? (n + 1) % int'(period_q) : n + 1;
	endfunction

	function automatic int lattice_hash(input int a, input int b, input int c);
		int h;
		h = pnoise_pkg::PERM[a & 255];
		h = pnoise_pkg::PERM[(h + b) & 255];
		return pnoise_pkg::PERM[(h + c) & 255];
	endfunction

	function automatic void split_coord(input longint s, output int cell_idx,
			output longint frac);
		longint ip;
		ip = (s >>> 16) & 64'hFFFFFF;
		frac = s & 64'hFFFF;
		if (period_q != 0 && (ip > period_q || (ip == period_q && frac > 0)))
			ip = (ip - period_q) & 64'hFFFFFF;
		cell_idx = int'(ip & 255);
	endfunction

	function automatic longint octave_noise(input longint sx, input longint sy,
			input longint sz);
		int xi, yi, zi, xn, yn, zn;
		longint xf, yf, zf, u, v, w, a1, a2, b1, b2, r;
		split_coord(sx, xi, xf);
		split_coord(sy, yi, yf);
		split_coord(sz, zi, zf);
		u = fade(xf);
		v = fade(yf);
		w = fade(zf);
		xn = step_cell(xi);
		yn = step_cell(yi);
		zn = step_cell(zi);
		a1 = blend(corner_dot(lattice_hash(xi, yi, zi), xf, yf, zf),
			corner_dot(lattice_hash(xn, yi, zi), xf - FX_ONE, yf, zf), u);
		a2 = blend(corner_dot(lattice_hash(xi, yn, zi), xf, yf - FX_ONE, zf),
			corner_dot(lattice_hash(xn, yn, zi), xf - FX_ONE, yf - FX_ONE, zf), u);
		b1 = blend(a1, a2, v);
		a1 = blend(corner_dot(lattice_hash(xi, yi, zn), xf, yf, zf - FX_ONE),
			corner_dot(lattice_hash(xn, yi, zn), xf - FX_ONE, yf, zf - FX_ONE), u);
		a2 = blend(corner_dot(lattice_hash(xi, yn, zn), xf, yf - FX_ONE, zf - FX_ONE),
			corner_dot(lattice_hash(xn, yn, zn), xf - FX_ONE, yf - FX_ONE,
			zf - FX_ONE), u);
		b2 = blend(a1, a2, v);
		r = blend(b1, b2, w) + FX_ONE;
		if (r < 0) r = 0;
		r = r >>> 1;
		if (r > FX_ONE) r = FX_ONE;
		return r;
	endfunction

	function automatic logic [15:0] fractal_noise(input logic [31:0] cx,
			input logic [31:0] cy, input logic [31:0] cz);
		int n;
		longint unsigned total, wsum, amp, q;
		n = octaves_q;
		total = 0;
		wsum = 0;
		amp = 32768;
		if (n < 1) n = 1;
		if (n > 8) n = 8;
		for (int i = 0; i < n; i++) begin
			total += longint'(octave_noise(longint'(cx) << i, longint'(cy) << i,
				longint'(cz) << i)) * amp;
			wsum += amp;
			amp = (amp * persist_q) >> 15;
		end
		q = total / wsum;
		if (q > 65535) q = 65535;
		return q[15:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [15:0] want;
		if (!arst_n) begin
			octaves_q = 4'd1;
			persist_q = 16'd16384;
			period_q = 8'd0;
			expected_noise.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					pnoise_pkg::REG_OCTAVES: octaves_q = pwdata[3:0];
					pnoise_pkg::REG_PERSIST: persist_q = pwdata[15:0];
					pnoise_pkg::REG_REPEAT: period_q = pwdata[7:0];
					default: ;
				endcase
			end
			if (noise_valid && noise_ready) begin
				if (expected_noise.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("Unexpected noise transaction: value %0d", noise_value);
				end else begin
					want = expected_noise.pop_front();
					if (want !== noise_value) begin
						errors++;
						if (errors <= 10)
							$display("noise_value mismatch: expected %0d, got %0d",
								want, noise_value);
					end
				end
			end
			if (coord_valid && coord_ready)
				expected_noise.push_back(fractal_noise(coord_x, coord_y, coord_z));
			pending = expected_noise.size();
		end
	end
endmodule

FILE: test/testbench.sv
// Top of the noise core testbench: clock, reset, register phases and point traffic.
// Depends on perlin_noise_3d_octaves_core, noise_checker and pnoise_pkg.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint CYCLE_LIMIT = 12_000_000;

	logic        clk, arst_n;
	logic        psel, penable, pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	logic        coord_valid, coord_ready;
	logic [31:0] coord_x, coord_y, coord_z;
	logic        noise_valid, noise_ready;
	logic [15:0] noise_value;
	int          errors, pending;
	longint      cycles;
	bit          sender_busy_mode, receiver_busy_mode;

	perlin_noise_3d_octaves_core u_dut (.*);

	noise_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic reg_write(input logic [1:0] index, input logic [31:0] value);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {index, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic send_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
		int gap;
		gap = sender_busy_mode ? pick_gap() : 0;
		if (gap > 0) begin
			coord_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		coord_valid = 1'b1;
		coord_x = x;
		coord_y = y;
		coord_z = z;
		do @(posedge clk); while (!coord_ready);
		@(negedge clk);
	endtask

	task automatic drain();
		coord_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_coord(input int period);
		int r;
		r = $urandom_range(0, 9);
		if (r < 4) return $urandom();
		if (r < 6) return {8'd0, 8'($urandom_range(0, 15)), 16'($urandom())};
		if (r < 8) return {16'($urandom_range(0, period + 2)), 16'($urandom())};
		if (r < 9) return {16'($urandom()), 16'($urandom_range(0, 1) ? 16'hFFFF : 16'h0)};
		return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
	endfunction

	initial begin
		int oct_tab [8] = '{1, 8, 0, 15, 3, 5, 2, 8};
		int per_tab [8] = '{16384, 65535, 0, 32768, 12000, 16384, 65535, 1};
		int rep_tab [8] = '{0, 0, 255, 1, 16, 0, 255, 7};
		int period;
		sender_busy_mode = 1'b1;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		coord_valid = 1'b0;
		coord_x = '0;
		coord_y = '0;
		coord_z = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_point(32'h0, 32'h0, 32'h0);
		send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
		send_point(32'h0000_FFFF, 32'h0000_8000, 32'h0000_0001);
		send_point(32'h00FF_8000, 32'h0100_4000, 32'hFFFF_0000);
		send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_AAAA);
		for (int h = 0; h < 8; h++)
			send_point(h << 16 | 16'h3A7C, (h * 37) << 16 | 16'hC35, (h * 91) << 16 | 16'h9001);
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			if (ph < 8) begin
				reg_write(pnoise_pkg::REG_OCTAVES, oct_tab[ph]);
				reg_write(pnoise_pkg::REG_PERSIST, per_tab[ph]);
				reg_write(pnoise_pkg::REG_REPEAT, rep_tab[ph]);
				period = rep_tab[ph];
			end else begin
				reg_write(pnoise_pkg::REG_OCTAVES, $urandom_range(0, 15));
				reg_write(pnoise_pkg::REG_PERSIST, $urandom());
				period = $urandom_range(0, 255);
				reg_write(pnoise_pkg::REG_REPEAT, period);
			end
			if (period != 0) begin
				send_point(period << 16, period << 16 | 1, (period - 1) << 16 | 16'hFFFF);
				send_point((period + 1) << 16, 32'h0, period << 16 | 16'h8000);
			end
			for (int k = 0; k < 133; k++) begin
				if (k % 40 == 0) sender_busy_mode = $urandom_range(0, 3) != 0;
				send_point(rand_coord(period), rand_coord(period), rand_coord(period));
			end
			sender_busy_mode = 1'b1;
			drain();
		end

		repeat (200) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int stall;
		stall = 0;
		noise_ready = 1'b0;
		receiver_busy_mode = 1'b1;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 999) == 0) receiver_busy_mode = ~receiver_busy_mode;
			if (stall > 0) begin
				noise_ready = 1'b0;
				stall--;
			end else begin
				noise_ready = 1'b1;
				if (receiver_busy_mode) stall = pick_gap();
			end
		end
	end
endmodule
